### rtl/bsc_pkg.sv
`default_nettype none

package bsc_pkg;

    // Field and register widths
    localparam int RAW_W     = 16;
    localparam int VALUE_W   = 16;
    localparam int COEFF_W   = 16;
    localparam int CFG_W     = 32;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);

    // Datapath widths
    localparam int DIFF_W  = RAW_W + 1;   // raw minus a 16-bit reference
    localparam int DUT_W   = 28;          // d minus curve term, curve < 2^26
    localparam int TERM_W  = 40;          // stored offset and sensitivity terms
    localparam int ACC_W   = 60;          // pressure accumulation
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int SPLIT_W = 20;          // sensitivity term split for the multiplier

    // Fixed constants of the compensation
    localparam logic [RAW_W-1:0]       PRESS_ZERO_RAW = 16'd7168;
    localparam logic signed [DIFF_W:0] OFFSET_BIAS    = 18'sd1024;
    localparam logic signed [ACC_W-1:0] TEMP_BASE     = 60'sd250;
    localparam logic signed [ACC_W-1:0] PRESS_BASE    = 60'sd150;
    localparam logic signed [ACC_W-1:0] SAT_MAX       = 60'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_MIN       = -60'sd32768;

    // Configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_SENS_BASE   = 3'd0,
        REG_OFFSET_BASE = 3'd1,
        REG_SENS_TC     = 3'd2,
        REG_OFFSET_TC   = 3'd3,
        REG_REF_TEMP    = 3'd4,
        REG_TEMP_SLOPE  = 3'd5,
        REG_PRESS_TRIM  = 3'd6,
        REG_CURVE       = 3'd7
    } t_reg_idx;

    localparam logic [COEFF_W-1:0] OFFSET_TC_RESET = 16'd1024;

    // Sample kinds
    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    // Coefficient set handed from the register bank to the datapath
    typedef struct packed {
        logic [COEFF_W-1:0] sens_base;
        logic [COEFF_W-1:0] offset_base;
        logic [COEFF_W-1:0] sens_tc;
        logic [COEFF_W-1:0] offset_tc;
        logic [COEFF_W-1:0] ref_temp;
        logic [COEFF_W-1:0] temp_slope;
        logic [COEFF_W-1:0] press_trim;
        logic [7:0]         curve_a;
        logic [7:0]         curve_b;
        logic [7:0]         curve_shift;
        logic [7:0]         div_shift;
    } t_coeffs;

endpackage

`default_nettype wire

### rtl/bsc_regs.sv
`default_nettype none

module bsc_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bsc_pkg::REG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [bsc_pkg::CFG_W-1:0]     i_cfg_wdata,
    output bsc_pkg::t_coeffs                   o_coeffs
);
    import bsc_pkg::*;

    t_coeffs r_coeffs;

    // Coefficient bank, written one register at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs.sens_base   <= '0;
            r_coeffs.offset_base <= '0;
            r_coeffs.sens_tc     <= '0;
            r_coeffs.offset_tc   <= OFFSET_TC_RESET;
            r_coeffs.ref_temp    <= '0;
            r_coeffs.temp_slope  <= '0;
            r_coeffs.press_trim  <= '0;
            r_coeffs.curve_a     <= '0;
            r_coeffs.curve_b     <= '0;
            r_coeffs.curve_shift <= '0;
            r_coeffs.div_shift   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_SENS_BASE:   r_coeffs.sens_base   <= i_cfg_wdata[COEFF_W-1:0];
                REG_OFFSET_BASE: r_coeffs.offset_base <= i_cfg_wdata[COEFF_W-1:0];
                REG_SENS_TC:     r_coeffs.sens_tc     <= i_cfg_wdata[COEFF_W-1:0];
                REG_OFFSET_TC:   r_coeffs.offset_tc   <= i_cfg_wdata[COEFF_W-1:0];
                REG_REF_TEMP:    r_coeffs.ref_temp    <= i_cfg_wdata[COEFF_W-1:0];
                REG_TEMP_SLOPE:  r_coeffs.temp_slope  <= i_cfg_wdata[COEFF_W-1:0];
                REG_PRESS_TRIM:  r_coeffs.press_trim  <= i_cfg_wdata[COEFF_W-1:0];
                REG_CURVE: begin
                    r_coeffs.curve_a     <= i_cfg_wdata[7:0];
                    r_coeffs.curve_b     <= i_cfg_wdata[15:8];
                    r_coeffs.curve_shift <= i_cfg_wdata[23:16];
                    r_coeffs.div_shift   <= i_cfg_wdata[31:24];
                end
                default: ;
            endcase
        end
    end

    assign o_coeffs = r_coeffs;

endmodule

`default_nettype wire

### rtl/bsc_mul.sv
`default_nettype none

module bsc_mul (
    input  wire logic                               i_clk,
    input  wire logic signed [bsc_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [bsc_pkg::MUL_B_W-1:0] i_b,
    output logic signed [bsc_pkg::MUL_P_W-1:0]      o_p
);
    import bsc_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    // Signed multiply, product registered
    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

### rtl/barometer_sample_compensation.sv
// Barometer sample compensation. Each request carries a raw 16-bit converter
// reading (tdata) tagged in tuser as a temperature (0) or pressure (1) sample,
// and gives exactly one result: temperature in 0.1 degC or pressure in 0.1 hPa
// as a 16-bit signed value, clipped with a flag when out of range. A
// temperature sample also refreshes the stored offset and sensitivity terms
// that later pressure samples use; pressure before any temperature uses zero
// terms. All products but the times-ten step of pressure come from one
// registered 34 x 18 signed multiplier under a small sequencer, so the input
// is taken one sample at a time: it is ready again once the result is in the
// output register, which waits for the previous result to leave. The user
// must write coefficients on the configuration port only while the block is
// idle; the block itself does not enforce this.
`default_nettype none

module barometer_sample_compensation (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [bsc_pkg::REG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [bsc_pkg::CFG_W-1:0]     i_cfg_wdata,
    // sample requests
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [15:0]                   i_s_axis_tdata,  // [15:0] raw_sample
    input  wire logic                          i_s_axis_tuser,  // [0] op
    // results
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [15:0]                        o_m_axis_tdata,  // [15:0] value
    output logic [1:0]                         o_m_axis_tuser   // [0] kind, [1] saturated
);
    import bsc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_CURVE,
        S_DUT,
        S_OFF,
        S_SENS,
        S_TEMP,
        S_TSUM,
        S_PLO,
        S_PHI,
        S_PSUM,
        S_PX,
        S_PMUL10,
        S_PFIN,
        S_OUT
    } t_state;

    t_coeffs coeffs;

    t_state                    r_state;
    logic                      r_kind;
    logic                      r_ge;
    logic signed [DIFF_W-1:0]  r_d;
    logic signed [DUT_W-1:0]   r_dut;
    logic signed [DUT_W-1:0]   r_div;
    logic signed [TERM_W-1:0]  r_offset;
    logic signed [TERM_W-1:0]  r_sens;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_valid;
    logic [VALUE_W-1:0]        r_out_value;
    logic                      r_out_kind;
    logic                      r_out_sat;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    logic                      in_acc;
    logic                      out_free;
    logic [DUT_W-2:0]          curve;
    logic signed [DUT_W-1:0]   dut;
    logic [DUT_W-1:0]          dut_mag;
    logic [DUT_W-1:0]          div_mag;
    logic signed [TERM_W-1:0]  off_sum;
    logic signed [DIFF_W:0]    off_tc;
    logic signed [ACC_W-1:0]   px;
    logic                      sat_hi;
    logic                      sat_lo;

    bsc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_coeffs    (coeffs)
    );

    bsc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // Curve term: product is non-negative and below 2^26
    assign curve   = prod[DUT_W-2:0] >> coeffs.curve_shift;
    assign dut     = DUT_W'(r_d) - $signed({1'b0, curve});

    // dUT / 2^D, truncated toward zero
    assign dut_mag = r_dut[DUT_W-1] ? DUT_W'(-r_dut) : DUT_W'(r_dut);
    assign div_mag = dut_mag >> coeffs.div_shift;

    assign off_tc  = $signed({2'b0, coeffs.offset_tc}) - OFFSET_BIAS;
    assign off_sum = TERM_W'(prod >>> 14) + $signed(TERM_W'(coeffs.offset_base));

    assign px      = (r_acc >>> 14) - ACC_W'(r_offset);

    assign sat_hi  = r_acc > SAT_MAX;
    assign sat_lo  = r_acc < SAT_MIN;

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQ: begin
                mul_a = MUL_A_W'(r_d);
                mul_b = MUL_B_W'(r_d);
            end
            S_CURVE: begin
                mul_a = $signed(MUL_A_W'(prod[32:14]));
                mul_b = $signed(MUL_B_W'(r_ge ? coeffs.curve_a : coeffs.curve_b));
            end
            S_OFF: begin
                mul_a = MUL_A_W'(r_dut);
                mul_b = MUL_B_W'(off_tc);
            end
            S_SENS: begin
                mul_a = MUL_A_W'(r_dut);
                mul_b = $signed(MUL_B_W'(coeffs.sens_tc));
            end
            S_TEMP: begin
                mul_a = MUL_A_W'(r_dut);
                mul_b = $signed(MUL_B_W'(coeffs.temp_slope));
            end
            S_PLO: begin
                mul_a = $signed(MUL_A_W'(r_sens[SPLIT_W-1:0]));
                mul_b = MUL_B_W'(r_d);
            end
            S_PHI: begin
                mul_a = MUL_A_W'($signed(r_sens[TERM_W-1:SPLIT_W]));
                mul_b = MUL_B_W'(r_d);
            end
            default: ;
        endcase
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_offset    <= '0;
            r_sens      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken; in S_OUT the load below decides the flag
            if (r_out_valid && i_m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind <= i_s_axis_tuser;
                        r_ge   <= i_s_axis_tdata >= coeffs.ref_temp;
                        if (i_s_axis_tuser == KIND_PRESS) begin
                            r_d     <= $signed({1'b0, i_s_axis_tdata})
                                       - $signed({1'b0, PRESS_ZERO_RAW});
                            r_state <= S_PLO;
                        end else begin
                            r_d     <= $signed({1'b0, i_s_axis_tdata})
                                       - $signed({1'b0, coeffs.ref_temp});
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ:    r_state <= S_CURVE;
                S_CURVE: r_state <= S_DUT;
                S_DUT: begin
                    r_dut   <= dut;
                    r_state <= S_OFF;
                end
                S_OFF:   r_state <= S_SENS;
                S_SENS: begin
                    r_offset <= off_sum <<< 2;
                    r_state  <= S_TEMP;
                end
                S_TEMP: begin
                    r_sens  <= TERM_W'(prod >>> 10) + $signed(TERM_W'(coeffs.sens_base));
                    r_div   <= r_dut[DUT_W-1] ? -$signed(div_mag) : $signed(div_mag);
                    r_state <= S_TSUM;
                end
                S_TSUM: begin
                    r_acc   <= TEMP_BASE + ACC_W'(prod >>> 16) - ACC_W'(r_div);
                    r_state <= S_OUT;
                end
                S_PLO:   r_state <= S_PHI;
                S_PHI: begin
                    r_acc   <= ACC_W'(prod);
                    r_state <= S_PSUM;
                end
                S_PSUM: begin
                    r_acc   <= r_acc + (ACC_W'(prod) <<< SPLIT_W);
                    r_state <= S_PX;
                end
                S_PX: begin
                    r_acc   <= px;
                    r_state <= S_PMUL10;
                end
                S_PMUL10: begin
                    r_acc   <= (r_acc <<< 3) + (r_acc <<< 1);
                    r_state <= S_PFIN;
                end
                S_PFIN: begin
                    r_acc   <= (r_acc >>> 5) + $signed(ACC_W'(coeffs.press_trim))
                               + PRESS_BASE;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_kind;
                        r_out_sat   <= sat_hi || sat_lo;
                        priority if (sat_hi) begin
                            r_out_value <= SAT_MAX[VALUE_W-1:0];
                        end else if (sat_lo) begin
                            r_out_value <= SAT_MIN[VALUE_W-1:0];
                        end else begin
                            r_out_value <= r_acc[VALUE_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = {r_out_sat, r_out_kind};

endmodule

`default_nettype wire

### rtl/bsc_checker.sv
`default_nettype none

module bsc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // One request at a time: busy after taking a request
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready straight after a request");

    // A stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

    // A clipped result sits at one of the range limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |->
        (o_m_axis_tdata == 16'h7fff || o_m_axis_tdata == 16'h8000))
        else $error("saturation flag with value inside range");

endmodule

bind barometer_sample_compensation bsc_checker u_bsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

### tb/tb_barometer_sample_compensation.sv
`timescale 1ns / 1ps

module tb_barometer_sample_compensation;
    import bsc_pkg::*;

    localparam int     CLK_PERIOD     = 10;
    localparam int     CYCLE_LIMIT    = 400000;
    localparam int     RAND_PHASES    = 6;
    localparam int     PHASE_ITEMS    = 315;
    localparam int     RX_HOLD_CYCLES = 300;
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     MAX_REPORTS    = 10;
    localparam longint PRESS_ZERO     = 7168;
    localparam longint TC_BIAS        = 1024;
    localparam longint TEMP_OFFSET    = 250;
    localparam longint PRESS_OFFSET   = 150;
    localparam longint VALUE_MAX      = 32767;
    localparam longint VALUE_MIN      = -32768;

    typedef struct {
        logic              op;
        logic [RAW_W-1:0]  raw;
    } t_sample;

    typedef struct {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic               sat;
    } t_reading;

    // DUT connections, every driven input known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;
    logic [1:0]           m_tuser;

    // Stimulus, expectations and the compensation state mirror
    t_sample    sample_queue[$];
    t_reading   expected_readings[$];
    t_sample    on_bus;
    logic [CFG_W-1:0] coeff_mirror [REG_COUNT];
    logic [CFG_W-1:0] coeff_set    [REG_COUNT];
    longint     offset_mirror = 0;
    longint     sens_mirror   = 0;

    // Flow control knobs
    int tx_idle_pct = 38;
    int rx_idle_pct = 38;
    bit tx_pause    = 1'b0;
    int rx_hold_req  = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;

    // Bookkeeping
    int cycle_count    = 0;
    int accepted_count = 0;
    int mismatch_count = 0;
    int temp_seen      = 0;
    int press_seen     = 0;
    int sat_seen       = 0;
    int coeff_sets     = 1;

    barometer_sample_compensation u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [15:0] raw_sample
        .i_s_axis_tuser  (s_tuser),   // [0] op
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [15:0] value
        .o_m_axis_tuser  (m_tuser)    // [0] kind, [1] saturated
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Compensate one sample against the mirrored coefficients and terms
    function automatic t_reading compensate_sample(t_sample s);
        longint   raw, c1, c2, c3, c4, c5, c6, c7;
        longint   ab, d, curve, dut, div_term, x, v;
        int       curve_shift, div_shift;
        t_reading r;
        raw = longint'(s.raw);
        c1  = longint'(coeff_mirror[REG_SENS_BASE][15:0]);
        c2  = longint'(coeff_mirror[REG_OFFSET_BASE][15:0]);
        c3  = longint'(coeff_mirror[REG_SENS_TC][15:0]);
        c4  = longint'(coeff_mirror[REG_OFFSET_TC][15:0]);
        c5  = longint'(coeff_mirror[REG_REF_TEMP][15:0]);
        c6  = longint'(coeff_mirror[REG_TEMP_SLOPE][15:0]);
        c7  = longint'(coeff_mirror[REG_PRESS_TRIM][15:0]);
        curve_shift = int'(coeff_mirror[REG_CURVE][23:16]);
        div_shift   = int'(coeff_mirror[REG_CURVE][31:24]);
        if (s.op == KIND_TEMP) begin
            d = raw - c5;
            if (raw >= c5)
                ab = longint'(coeff_mirror[REG_CURVE][7:0]);
            else
                ab = longint'(coeff_mirror[REG_CURVE][15:8]);
            curve = ((d * d) >>> 14) * ab;
            // shifts of 63 and up clear the curve term
            if (curve_shift >= 63)
                curve = 0;
            else
                curve = curve >>> curve_shift;
            dut = d - curve;
            offset_mirror = (c2 + (((c4 - TC_BIAS) * dut) >>> 14)) * 4;
            sens_mirror   = c1 + ((c3 * dut) >>> 10);
            // divider term truncates toward zero
            if (div_shift >= 63)
                div_term = 0;
            else if (dut >= 0)
                div_term = dut >> div_shift;
            else
                div_term = -((-dut) >> div_shift);
            v = TEMP_OFFSET + ((dut * c6) >>> 16) - div_term;
        end else begin
            x = ((sens_mirror * (raw - PRESS_ZERO)) >>> 14) - offset_mirror;
            v = ((x * 10) >>> 5) + c7 + PRESS_OFFSET;
        end
        r.kind = s.op;
        r.sat  = 1'b0;
        if (v > VALUE_MAX) begin
            v = VALUE_MAX;
            r.sat = 1'b1;
        end else if (v < VALUE_MIN) begin
            v = VALUE_MIN;
            r.sat = 1'b1;
        end
        r.value = v[15:0];
        return r;
    endfunction

    // Request driver: holds each request until accepted, idles at random
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_readings.push_back(compensate_sample(on_bus));
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (!tx_pause && sample_queue.size() != 0 &&
                    $urandom_range(99) >= tx_idle_pct) begin
                    on_bus = sample_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= on_bus.raw;
                    s_tuser  <= on_bus.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge clk) begin
        t_reading want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (m_tuser[0] == KIND_TEMP) temp_seen++;
                else press_seen++;
                if (m_tuser[1]) sat_seen++;
                if (expected_readings.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result kind=%0b value=%0d sat=%0b",
                                 $realtime, m_tuser[0], $signed(m_tdata), m_tuser[1]);
                end else begin
                    want = expected_readings.pop_front();
                    if (m_tuser[0] !== want.kind || m_tdata !== want.value ||
                        m_tuser[1] !== want.sat) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"%0t: mismatch exp kind=%0b value=%0d sat=%0b,",
                                      " got kind=%0b value=%0d sat=%0b"},
                                     $realtime, want.kind, $signed(want.value), want.sat,
                                     m_tuser[0], $signed(m_tdata), m_tuser[1]);
                    end
                end
            end
            // long hold-off on request, otherwise random stalls
            if (rx_hold_left > 0) begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end else if (rx_hold_req != rx_hold_seen) begin
                rx_hold_seen = rx_hold_req;
                rx_hold_left = RX_HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles, %0d results outstanding",
                     cycle_count, expected_readings.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_coeff(t_reg_idx idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        coeff_mirror[idx] = (idx == REG_CURVE) ? val : {16'h0, val[15:0]};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_coeff_set();
        for (int i = 0; i < REG_COUNT; i++)
            write_coeff(t_reg_idx'(i), coeff_set[i]);
        coeff_sets++;
    endtask

    task automatic queue_sample(logic op, logic [RAW_W-1:0] raw);
        t_sample s;
        s.op  = op;
        s.raw = raw;
        sample_queue.push_back(s);
    endtask

    // Wait until every request has gone and every result has come back
    task automatic drain();
        do @(negedge clk);
        while (sample_queue.size() != 0 || s_tvalid || expected_readings.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    function automatic logic [15:0] pick_coeff();
        case ($urandom_range(6))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(255));
            3:       return 16'($urandom_range(1536, 512));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_shift();
        int r;
        r = $urandom_range(9);
        if (r < 6)
            return 8'($urandom_range(20));
        else if (r < 8)
            return 8'($urandom_range(255, 63));
        else
            return 8'($urandom_range(255));
    endfunction

    // Random coefficients; junk in the unused upper half of 16-bit registers
    task automatic random_coeff_set();
        logic [31:0] junk;
        for (int i = 0; i < REG_CURVE; i++) begin
            junk = $urandom;
            coeff_set[i] = {junk[31:16], pick_coeff()};
        end
        coeff_set[REG_CURVE] = {pick_shift(), pick_shift(),
                                8'($urandom), 8'($urandom)};
    endtask

    function automatic logic [15:0] pick_raw(logic op);
        int centre, v;
        case ($urandom_range(7))
            0:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1, 2: begin
                centre = (op == KIND_TEMP) ? int'(coeff_mirror[REG_REF_TEMP][15:0]) :
                                             int'(PRESS_ZERO);
                v = centre + int'($urandom_range(2047)) - 1024;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return 16'(v);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly a temperature sample followed by a few pressure samples
    task automatic queue_random_items(int count);
        int n, k;
        logic op;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 80) begin
                queue_sample(KIND_TEMP, pick_raw(KIND_TEMP));
                k = $urandom_range(4, 1);
                for (int j = 0; j < k; j++)
                    queue_sample(KIND_PRESS, pick_raw(KIND_PRESS));
                n += k + 1;
            end else begin
                op = 1'($urandom_range(1));
                queue_sample(op, pick_raw(op));
                n++;
            end
        end
    endtask

    initial begin
        int mark;
        for (int i = 0; i < REG_COUNT; i++)
            coeff_mirror[i] = '0;
        coeff_mirror[REG_OFFSET_TC] = {16'h0, OFFSET_TC_RESET};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset coefficients: pressure before any temperature, raw extremes
        queue_sample(KIND_PRESS, 16'h0000);
        queue_sample(KIND_PRESS, 16'hFFFF);
        queue_sample(KIND_TEMP,  16'h0000);
        queue_sample(KIND_TEMP,  16'hFFFF);
        queue_sample(KIND_PRESS, 16'd7168);
        queue_sample(KIND_PRESS, 16'h0000);
        drain();

        // All coefficients at maximum, both shifts past 63
        for (int i = 0; i < REG_COUNT; i++)
            coeff_set[i] = 32'hFFFF_FFFF;
        apply_coeff_set();
        queue_sample(KIND_TEMP,  16'h0000);
        queue_sample(KIND_PRESS, 16'hFFFF);
        queue_sample(KIND_TEMP,  16'hFFFF);
        queue_sample(KIND_PRESS, 16'h0000);
        queue_sample(KIND_TEMP,  16'h8000);
        queue_sample(KIND_PRESS, 16'd7168);
        drain();

        // Largest curve term (shift 0), divider just below the cut-off
        coeff_set[REG_REF_TEMP] = 32'h0000_8000;
        coeff_set[REG_CURVE]    = 32'h3E00_FFFF;
        apply_coeff_set();
        queue_sample(KIND_TEMP,  16'hFFFF);
        queue_sample(KIND_PRESS, 16'hFFFF);
        queue_sample(KIND_TEMP,  16'h0000);
        queue_sample(KIND_PRESS, 16'h0000);
        queue_sample(KIND_TEMP,  16'h8000);
        queue_sample(KIND_PRESS, 16'h1C00);
        drain();

        // Zero coefficients, divider shift 0, distinct A and B
        for (int i = 0; i < REG_COUNT; i++)
            coeff_set[i] = 32'h0;
        coeff_set[REG_REF_TEMP] = 32'h0000_7000;
        coeff_set[REG_CURVE]    = 32'h000A_80C0;
        apply_coeff_set();
        queue_sample(KIND_TEMP,  16'h6FFF);
        queue_sample(KIND_PRESS, 16'h5555);
        queue_sample(KIND_TEMP,  16'h7000);
        queue_sample(KIND_PRESS, 16'hAAAA);
        queue_sample(KIND_TEMP,  16'hFFFF);
        queue_sample(KIND_PRESS, 16'hFFFF);
        drain();

        // Random phases, one coefficient set each
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_coeff_set();
            if (ph == 4) begin
                // strongest sensitivity with the full curve term
                for (int i = 0; i < REG_CURVE; i++)
                    coeff_set[i] = 32'h0000_FFFF;
                coeff_set[REG_CURVE] = 32'h0000_FFFF;
            end
            apply_coeff_set();
            tx_idle_pct = (ph == 1) ? 0 : 38;
            rx_idle_pct = (ph == 1) ? 0 : 38;
            queue_random_items(PHASE_ITEMS);
            if (ph == 0) begin
                // receiver holds off while requests keep coming
                mark = accepted_count + 20;
                do @(negedge clk); while (accepted_count < mark);
                rx_hold_req++;
            end else if (ph == 2) begin
                // sender stops until every result is home
                do @(negedge clk); while (sample_queue.size() > PHASE_ITEMS / 2);
                tx_pause = 1'b1;
                do @(negedge clk); while (s_tvalid || expected_readings.size() != 0);
                repeat (10) @(negedge clk);
                tx_pause = 1'b0;
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Checked %0d temperature and %0d pressure results over %0d coefficient sets",
                 temp_seen, press_seen, coeff_sets);
        $display("%0d results saturated, %0d mismatches", sat_seen, mismatch_count);
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
rtl/bsc_pkg.sv
rtl/bsc_regs.sv
rtl/bsc_mul.sv
rtl/barometer_sample_compensation.sv
rtl/bsc_checker.sv
tb/tb_barometer_sample_compensation.sv
